@@ sv/knn3_pkg.sv @@
// ----------------------------------------------------------------------------
// knn3_pkg
// Shared constants, codes and types for the three-nearest-neighbour classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package knn3_pkg;

   // storage geometry (the store sizes are powers of two)
   localparam int MAX_ATTRS   = 512;
   localparam int MAX_TRAIN   = 1024;
   localparam int NEIGHBOURS  = 3;
   localparam int ATTR_W      = $clog2(MAX_ATTRS);
   localparam int TRAIN_W     = $clog2(MAX_TRAIN);
   localparam int TRAIN_DEPTH = MAX_TRAIN * MAX_ATTRS;
   localparam int SLOT_W      = $clog2(NEIGHBOURS);

   // field and register widths
   localparam int CMD_W        = 2;
   localparam int FEAT_W       = 16;
   localparam int LABEL_W      = 8;
   localparam int ATTR_CNT_W   = 10;
   localparam int TRAIN_CNT_W  = 11;
   localparam int CSR_ADDR_W   = 1;
   localparam int CSR_DATA_W   = 11;
   localparam int DIFF_W       = FEAT_W + 1;
   localparam int SQ_W         = 2 * DIFF_W;
   localparam int DIST_W       = 43;
   localparam int REQ_DATA_W   = 32;
   localparam int RSP_DATA_W   = 24;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_ATTR_COUNT  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TRAIN_COUNT = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_TRAIN = 2'd0,
      CMD_MASK  = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEARCH,
      ST_DRAIN,
      ST_LABEL,
      ST_LWAIT,
      ST_VOTE
   } state_type;

   // control that travels alongside one element through the distance pipe
   typedef struct packed {
      logic               valid;
      logic               first;
      logic               last;
      logic               zero;
      logic [TRAIN_W-1:0] idx;
   } elem_ctl_type;

endpackage

`default_nettype wire

@@ sv/knn3_ram.sv @@
// ----------------------------------------------------------------------------
// knn3_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module knn3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

@@ sv/knn3_mac.sv @@
// ----------------------------------------------------------------------------
// knn3_mac
// Shared difference, square and accumulate unit; emits one distance per vector.
// ----------------------------------------------------------------------------
`default_nettype none

module knn3_mac (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire knn3_pkg::elem_ctl_type          ctl_i,
   input  wire logic [knn3_pkg::FEAT_W-1:0]     query_i,
   input  wire logic [knn3_pkg::FEAT_W-1:0]     train_i,
   input  wire logic                            mask_i,
   output logic      [knn3_pkg::DIST_W-1:0]     dist_o,
   output logic      [knn3_pkg::TRAIN_W-1:0]    dist_idx_o,
   output logic                                 dist_valid_o,
   output logic                                 busy_o
);

   import knn3_pkg::*;

   elem_ctl_type              ctl_a_ff, ctl_b_ff, ctl_c_ff;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [DIFF_W-1:0]  diff_b_ff;
   logic signed [SQ_W-1:0]    sq_c_ff;
   logic        [DIST_W-1:0]  acc_ff, acc_in;
   logic        [TRAIN_W-1:0] idx_ff;
   logic                      done_ff;

   // ctl_a lines up with the registered RAM outputs
   assign diff = $signed({query_i[FEAT_W-1], query_i}) - $signed({train_i[FEAT_W-1], train_i});

   assign acc_in = (ctl_c_ff.first ? '0 : acc_ff) + DIST_W'(unsigned'(sq_c_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         ctl_c_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         ctl_a_ff <= ctl_i;
         ctl_b_ff <= ctl_a_ff;
         ctl_c_ff <= ctl_b_ff;
         done_ff  <= ctl_c_ff.valid & ctl_c_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      diff_b_ff <= (mask_i && !ctl_a_ff.zero) ? diff : '0;
      sq_c_ff   <= diff_b_ff * diff_b_ff;
      if (ctl_c_ff.valid) begin
         acc_ff <= acc_in;
         idx_ff <= ctl_c_ff.idx;
      end
   end

   assign dist_o       = acc_ff;
   assign dist_idx_o   = idx_ff;
   assign dist_valid_o = done_ff;
   assign busy_o       = ctl_a_ff.valid | ctl_b_ff.valid | ctl_c_ff.valid | done_ff;

endmodule

`default_nettype wire

@@ sv/knn3_rank.sv @@
// ----------------------------------------------------------------------------
// knn3_rank
// Sorted list of the three smallest distances and the neighbour vote.
// ----------------------------------------------------------------------------
`default_nettype none

module knn3_rank (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            clear_i,
   input  wire logic                            dist_valid_i,
   input  wire logic [knn3_pkg::DIST_W-1:0]     dist_i,
   input  wire logic [knn3_pkg::TRAIN_W-1:0]    idx_i,
   input  wire logic [knn3_pkg::LABEL_W-1:0]    labels_i [knn3_pkg::NEIGHBOURS],
   input  wire logic [knn3_pkg::SLOT_W-1:0]     filled_i,
   output logic      [knn3_pkg::TRAIN_W-1:0]    best_idx_o [knn3_pkg::NEIGHBOURS],
   output logic      [knn3_pkg::LABEL_W-1:0]    class_o,
   output logic      [knn3_pkg::TRAIN_W-1:0]    nearest_o
);

   import knn3_pkg::*;

   logic [DIST_W-1:0]  best_d_ff [NEIGHBOURS];
   logic [TRAIN_W-1:0] best_i_ff [NEIGHBOURS];
   logic               le0, le1, le2;
   logic [LABEL_W-1:0] l0, l1, l2, min01, min012;

   // list stays ascending, so the first slot that is not smaller takes the new
   // entry and the rest move down; equal distances go in front
   assign le0 = dist_i <= best_d_ff[0];
   assign le1 = dist_i <= best_d_ff[1];
   assign le2 = dist_i <= best_d_ff[2];

   always_ff @(posedge clock) begin
      if (reset || clear_i) begin
         for (int j = 0; j < NEIGHBOURS; j++) begin
            best_d_ff[j] <= '1;
            best_i_ff[j] <= '0;
         end
      end else if (dist_valid_i) begin
         best_d_ff[0] <= le0 ? dist_i : best_d_ff[0];
         best_i_ff[0] <= le0 ? idx_i  : best_i_ff[0];
         best_d_ff[1] <= le0 ? best_d_ff[0] : (le1 ? dist_i : best_d_ff[1]);
         best_i_ff[1] <= le0 ? best_i_ff[0] : (le1 ? idx_i  : best_i_ff[1]);
         best_d_ff[2] <= le1 ? best_d_ff[1] : (le2 ? dist_i : best_d_ff[2]);
         best_i_ff[2] <= le1 ? best_i_ff[1] : (le2 ? idx_i  : best_i_ff[2]);
      end
   end

   assign best_idx_o = best_i_ff;

   assign l0     = labels_i[0];
   assign l1     = labels_i[1];
   assign l2     = labels_i[2];
   assign min01  = (l0 <= l1) ? l0 : l1;
   assign min012 = (l2 < min01) ? l2 : min01;

   always_comb begin
      case (filled_i)
         2'd0:    class_o = '0;
         2'd1:    class_o = l0;
         2'd2:    class_o = min01;
         default: begin
            if (l0 == l1 || l0 == l2) begin
               class_o = l0;
            end else if (l1 == l2) begin
               class_o = l1;
            end else begin
               class_o = min012;
            end
         end
      endcase
   end

   assign nearest_o = (filled_i != '0) ? best_i_ff[0] : '0;

endmodule

`default_nettype wire

@@ sv/knn3_masked_classifier.sv @@
// ----------------------------------------------------------------------------
// knn3_masked_classifier
// Three-nearest-neighbour classifier over masked Q8.8 feature vectors.
// ----------------------------------------------------------------------------
//  channel | dir | carries
//  req_    | in  | training element, mask bit or query element
//  rsp_    | out | predicted class and index of the nearest training vector
//  csr_    | in  | attribute_count (0), training_count (1)
//
//  Load and mask requests are accepted back to back while the block is idle.
//  A closing query element starts a search over training_count vectors of
//  max(1, attribute_count) elements each, one element per cycle through the
//  shared multiply-accumulate, followed by drain, label reads and vote.
//  After reset every entry of the mask store is cleared with req_tready low.
//  A waiting result is held in the rsp_ register; a new vote waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module knn3_masked_classifier (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // req_tdata: feature_value[15:0], class_label[23:16], mask_bit[24], zeros
   input  wire logic [knn3_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: command[1:0]
   input  wire logic [knn3_pkg::CMD_W-1:0]        req_tuser,
   input  wire logic                              req_tlast,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // rsp_tdata: predicted_class[7:0], nearest_index[17:8], zeros
   output logic      [knn3_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_we,
   input  wire logic [knn3_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [knn3_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import knn3_pkg::*;

   state_type               state_ff, state_in;
   logic [ATTR_CNT_W-1:0]   attr_cnt_ff;
   logic [TRAIN_CNT_W-1:0]  train_cnt_ff;
   logic [ATTR_CNT_W-1:0]   attrs, attr_lim, att_ff;
   logic [TRAIN_CNT_W-1:0]  count_lim, ex_ff;
   logic [ATTR_W-1:0]       ep_ff, clr_ff;
   logic [TRAIN_W-1:0]      xp_ff;
   logic [SLOT_W-1:0]       lab_ff, rd_slot_ff, filled;
   logic                    rd_vld_ff;
   logic [LABEL_W-1:0]      lbl_ff [NEIGHBOURS];

   logic [FEAT_W-1:0]       req_feature;
   logic [LABEL_W-1:0]      req_label;
   logic                    req_mask;
   cmd_type                 req_cmd;
   logic                    accept, start, iss_last, ex_last, out_free;

   logic                    search_en, clear_list, lab_rd, clr_we, rsp_load;

   elem_ctl_type            iss;
   logic [FEAT_W-1:0]       q_rdata, t_rdata;
   logic                    m_rdata;
   logic [LABEL_W-1:0]      l_rdata;
   logic                    mask_we, mask_wdata;
   logic [ATTR_W-1:0]       mask_waddr;

   logic [DIST_W-1:0]       mac_dist;
   logic [TRAIN_W-1:0]      dist_idx;
   logic                    dist_valid, mac_busy;
   logic [TRAIN_W-1:0]      best_idx [NEIGHBOURS];
   logic [LABEL_W-1:0]      vote_class;
   logic [TRAIN_W-1:0]      nearest;

   logic                    rsp_tvalid_ff;
   logic [LABEL_W-1:0]      rsp_class_ff;
   logic [TRAIN_W-1:0]      rsp_near_ff;

   assign req_feature = req_tdata[FEAT_W-1:0];
   assign req_label   = req_tdata[FEAT_W +: LABEL_W];
   assign req_mask    = req_tdata[FEAT_W + LABEL_W];
   assign req_cmd     = cmd_type'(req_tuser);

   assign accept = req_tvalid & req_tready;
   assign start  = accept && req_cmd == CMD_QUERY && req_tlast;

   // oversized settings clamp to the store size
   assign attrs     = (attr_cnt_ff > ATTR_CNT_W'(MAX_ATTRS)) ? ATTR_CNT_W'(MAX_ATTRS)
                                                             : attr_cnt_ff;
   assign count_lim = (train_cnt_ff > TRAIN_CNT_W'(MAX_TRAIN)) ? TRAIN_CNT_W'(MAX_TRAIN)
                                                               : train_cnt_ff;
   // no attributes still walks one dead element per vector: distance zero
   assign attr_lim  = (attrs == '0) ? ATTR_CNT_W'(1) : attrs;
   assign filled    = (count_lim >= TRAIN_CNT_W'(NEIGHBOURS)) ? SLOT_W'(NEIGHBOURS)
                                                              : count_lim[SLOT_W-1:0];
   assign iss_last  = att_ff == attr_lim - ATTR_CNT_W'(1);
   assign ex_last   = ex_ff == count_lim - TRAIN_CNT_W'(1);
   assign out_free  = !rsp_tvalid_ff || rsp_tready;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_ff == ATTR_W'(MAX_ATTRS - 1)) state_in = ST_IDLE;
         ST_IDLE:   if (start) state_in = (count_lim == '0) ? ST_VOTE : ST_SEARCH;
         ST_SEARCH: if (iss_last && ex_last) state_in = ST_DRAIN;
         ST_DRAIN:  if (!mac_busy) state_in = ST_LABEL;
         ST_LABEL:  if (lab_ff == SLOT_W'(NEIGHBOURS - 1)) state_in = ST_LWAIT;
         ST_LWAIT:  state_in = ST_VOTE;
         ST_VOTE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      search_en  = 1'b0;
      clear_list = 1'b0;
      lab_rd     = 1'b0;
      clr_we     = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_CLEAR:  clr_we = 1'b1;
         ST_IDLE: begin
            req_tready = 1'b1;
            clear_list = start;
         end
         ST_SEARCH: search_en = 1'b1;
         ST_LABEL:  lab_rd = 1'b1;
         ST_VOTE:   rsp_load = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         attr_cnt_ff  <= ATTR_CNT_W'(1);
         train_cnt_ff <= TRAIN_CNT_W'(3);
         att_ff       <= '0;
         ex_ff        <= '0;
         ep_ff        <= '0;
         xp_ff        <= '0;
         clr_ff       <= '0;
         lab_ff       <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_ATTR_COUNT:  attr_cnt_ff  <= csr_wdata[ATTR_CNT_W-1:0];
               CSR_TRAIN_COUNT: train_cnt_ff <= csr_wdata[TRAIN_CNT_W-1:0];
               default: ;
            endcase
         end
         if (clr_we) begin
            clr_ff <= clr_ff + ATTR_W'(1);
         end
         // one element pointer shared by all commands; unused command leaves it
         if (accept && req_cmd != CMD_NONE) begin
            ep_ff <= req_tlast ? '0 : ep_ff + ATTR_W'(1);
         end
         if (accept && req_cmd == CMD_TRAIN && req_tlast) begin
            xp_ff <= xp_ff + TRAIN_W'(1);
         end
         if (start) begin
            att_ff <= '0;
            ex_ff  <= '0;
            lab_ff <= '0;
         end else if (search_en) begin
            att_ff <= iss_last ? '0 : att_ff + ATTR_CNT_W'(1);
            if (iss_last) begin
               ex_ff <= ex_ff + TRAIN_CNT_W'(1);
            end
         end
         if (lab_rd) begin
            lab_ff <= lab_ff + SLOT_W'(1);
         end
         rd_vld_ff <= lab_rd;
      end
   end

   always_ff @(posedge clock) begin
      rd_slot_ff <= lab_ff;
      if (rd_vld_ff) begin
         lbl_ff[rd_slot_ff] <= l_rdata;
      end
   end

   // ---------------------------------------------------------------- stores
   assign iss.valid = search_en;
   assign iss.first = att_ff == '0;
   assign iss.last  = iss_last;
   assign iss.zero  = attrs == '0;
   assign iss.idx   = ex_ff[TRAIN_W-1:0];

   assign mask_we    = clr_we | (accept && req_cmd == CMD_MASK);
   assign mask_waddr = clr_we ? clr_ff : ep_ff;
   assign mask_wdata = clr_we ? 1'b0 : req_mask;

   knn3_ram #(.WIDTH(FEAT_W), .DEPTH(TRAIN_DEPTH)) u_train_ram (
      .clock (clock),
      .we    (accept && req_cmd == CMD_TRAIN),
      .waddr ({xp_ff, ep_ff}),
      .wdata (req_feature),
      .raddr ({ex_ff[TRAIN_W-1:0], att_ff[ATTR_W-1:0]}),
      .rdata (t_rdata)
   );

   knn3_ram #(.WIDTH(FEAT_W), .DEPTH(MAX_ATTRS)) u_query_ram (
      .clock (clock),
      .we    (accept && req_cmd == CMD_QUERY),
      .waddr (ep_ff),
      .wdata (req_feature),
      .raddr (att_ff[ATTR_W-1:0]),
      .rdata (q_rdata)
   );

   knn3_ram #(.WIDTH(1), .DEPTH(MAX_ATTRS)) u_mask_ram (
      .clock (clock),
      .we    (mask_we),
      .waddr (mask_waddr),
      .wdata (mask_wdata),
      .raddr (att_ff[ATTR_W-1:0]),
      .rdata (m_rdata)
   );

   knn3_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_TRAIN)) u_label_ram (
      .clock (clock),
      .we    (accept && req_cmd == CMD_TRAIN && req_tlast),
      .waddr (xp_ff),
      .wdata (req_label),
      .raddr (best_idx[lab_ff]),
      .rdata (l_rdata)
   );

   // ---------------------------------------------------------------- datapath
   knn3_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .ctl_i        (iss),
      .query_i      (q_rdata),
      .train_i      (t_rdata),
      .mask_i       (m_rdata),
      .dist_o       (mac_dist),
      .dist_idx_o   (dist_idx),
      .dist_valid_o (dist_valid),
      .busy_o       (mac_busy)
   );

   knn3_rank u_rank (
      .clock        (clock),
      .reset        (reset),
      .clear_i      (clear_list),
      .dist_valid_i (dist_valid),
      .dist_i       (mac_dist),
      .idx_i        (dist_idx),
      .labels_i     (lbl_ff),
      .filled_i     (filled),
      .best_idx_o   (best_idx),
      .class_o      (vote_class),
      .nearest_o    (nearest)
   );

   // ---------------------------------------------------------------- result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_class_ff <= vote_class;
         rsp_near_ff  <= nearest;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - LABEL_W - TRAIN_W)'(0), rsp_near_ff, rsp_class_ff};

endmodule

`default_nettype wire

@@ tb/knn3_masked_classifier_tb.sv @@
// ----------------------------------------------------------------------------
// knn3_masked_classifier_tb
// Self-checking bench for the three-nearest-neighbour classifier: training
// vectors, mask bits and query vectors are streamed in with random idling on
// both sides. A behavioural predictor works out every vote, and the results
// are compared in order. Widest vectors, a longer training store,
// clamped and undersized register settings and random sessions.
// ----------------------------------------------------------------------------
`default_nettype none

module knn3_masked_classifier_tb;
   import knn3_pkg::*;

   localparam int          RANDOM_REQUESTS = 460;
   localparam int          RANDOM_WIDTH    = 8;
   localparam int          LONG_EXAMPLES   = 40;
   localparam int          SETTLE_CYCLES   = 16;
   localparam int          TAIL_CYCLES     = 40;
   localparam longint      TIMEOUT         = 3_000_000;
   localparam longint unsigned DIST_ONES   = (64'd1 << DIST_W) - 64'd1;

   typedef struct packed {
      logic [LABEL_W-1:0] predicted_class;
      logic [9:0]         nearest_index;
   } vote_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [CMD_W-1:0]       req_tuser  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // predictor state
   bit [FEAT_W-1:0]        train_feat    [TRAIN_DEPTH];
   bit                     feat_written  [TRAIN_DEPTH];
   bit [LABEL_W-1:0]       train_label   [MAX_TRAIN];
   bit                     label_written [MAX_TRAIN];
   bit                     mask_bits     [MAX_ATTRS];
   bit [FEAT_W-1:0]        query_feat    [MAX_ATTRS];
   int                     elem_ptr      = 0;
   int                     ex_ptr        = 0;
   logic [ATTR_CNT_W-1:0]  attr_cnt      = 10'd1;
   logic [TRAIN_CNT_W-1:0] train_cnt     = 11'd3;

   vote_type               pending_votes [$];
   int                     fails         = 0;
   int                     votes_checked = 0;
   int                     requests_sent = 0;
   bit                     steady        = 1'b0;
   int                     stall_left    = 0;

   knn3_masked_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint unsigned masked_sum(int ex, int attrs);
      longint unsigned sum;
      longint          d;
      sum = 0;
      for (int i = 0; i < attrs; i++) begin
         if (mask_bits[i]) begin
            d = longint'($signed(query_feat[i])) -
                longint'($signed(train_feat[ex * MAX_ATTRS + i]));
            sum += d * d;
         end
      end
      return sum & DIST_ONES;
   endfunction

   function automatic vote_type neighbour_vote();
      int              attrs, count, filled, idx, tmp_i;
      longint unsigned cand_d, tmp_d;
      longint unsigned best_d [NEIGHBOURS];
      int              best_i [NEIGHBOURS];
      logic [7:0]      l0, l1, l2;
      vote_type        v;
      attrs  = (attr_cnt > MAX_ATTRS) ? MAX_ATTRS : attr_cnt;
      count  = (train_cnt > MAX_TRAIN) ? MAX_TRAIN : train_cnt;
      filled = (count < NEIGHBOURS) ? count : NEIGHBOURS;
      for (int j = 0; j < NEIGHBOURS; j++) begin
         best_d[j] = DIST_ONES;
         best_i[j] = 0;
      end
      for (int e = 0; e < count; e++) begin
         cand_d = masked_sum(e, attrs);
         idx    = e;
         // equal distance displaces, so the later vector wins a tie
         for (int j = 0; j < NEIGHBOURS; j++) begin
            if (cand_d <= best_d[j]) begin
               tmp_d     = best_d[j];
               tmp_i     = best_i[j];
               best_d[j] = cand_d;
               best_i[j] = idx;
               cand_d    = tmp_d;
               idx       = tmp_i;
            end
         end
      end
      v  = '0;
      l0 = train_label[best_i[0]];
      l1 = train_label[best_i[1]];
      l2 = train_label[best_i[2]];
      case (filled)
         0: v.predicted_class = 8'd0;
         1: v.predicted_class = l0;
         2: v.predicted_class = (l0 <= l1) ? l0 : l1;
         default: begin
            if (l0 == l1 || l0 == l2)
               v.predicted_class = l0;
            else if (l1 == l2)
               v.predicted_class = l1;
            else begin
               v.predicted_class = l0;
               if (l1 < v.predicted_class) v.predicted_class = l1;
               if (l2 < v.predicted_class) v.predicted_class = l2;
            end
         end
      endcase
      if (filled != 0) v.nearest_index = 10'(best_i[0]);
      return v;
   endfunction

   function automatic void apply_request(cmd_type cmd, logic [FEAT_W-1:0] feat,
                                         logic [LABEL_W-1:0] label, logic mbit,
                                         logic last);
      int ep, xp;
      ep = elem_ptr;
      xp = ex_ptr;
      if (cmd == CMD_NONE) return;
      case (cmd)
         CMD_TRAIN: begin
            train_feat[xp * MAX_ATTRS + ep]   = feat;
            feat_written[xp * MAX_ATTRS + ep] = 1'b1;
            if (last) begin
               train_label[xp]   = label;
               label_written[xp] = 1'b1;
               ex_ptr            = (xp + 1) % MAX_TRAIN;
            end
         end
         CMD_MASK: mask_bits[ep] = mbit;
         default: begin
            query_feat[ep] = feat;
            if (last) pending_votes.insert(pending_votes.size(), neighbour_vote());
         end
      endcase
      elem_ptr = last ? 0 : (ep + 1) % MAX_ATTRS;
   endfunction

   // longest run of training vectors from index 0 fully written to attrs elements
   function automatic int safe_examples(int attrs);
      int n;
      bit ok;
      n  = 0;
      ok = 1'b1;
      while (ok && n < MAX_TRAIN) begin
         ok = label_written[n];
         for (int i = 0; i < attrs; i++)
            if (!feat_written[n * MAX_ATTRS + i]) ok = 1'b0;
         if (ok) n++;
      end
      return n;
   endfunction

   // ---------------------------------------------------------------- helpers

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [FEAT_W-1:0] pick_feature(bit narrow);
      logic [FEAT_W-1:0] v;
      if (narrow) begin
         v = $urandom_range(0, 6);
         v = v - 16'd3;
      end else if ($urandom_range(0, 4) == 0)
         v = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      else
         v = $urandom_range(0, 65535);
      return v;
   endfunction

   function automatic logic [LABEL_W-1:0] pick_label(bit narrow);
      return narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
   endfunction

   task automatic send_request(cmd_type cmd, logic [FEAT_W-1:0] feat,
                               logic [LABEL_W-1:0] label, logic mbit, logic last);
      int gap;
      gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_length();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {7'd0, mbit, label, feat};
      req_tuser  <= cmd;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      apply_request(cmd, feat, label, mbit, last);
      if (cmd != CMD_NONE) requests_sent++;
   endtask

   task automatic send_noise();
      if ($urandom_range(0, 1))
         send_request(CMD_NONE, $urandom_range(0, 65535), $urandom_range(0, 255),
                      $urandom_range(0, 1), $urandom_range(0, 1));
      else
         send_request(CMD_MASK, $urandom_range(0, 65535), $urandom_range(0, 255),
                      $urandom_range(0, 1), $urandom_range(0, 1));
   endtask

   // closes any half-walked vector so the next one starts at element 0
   task automatic align_pointer();
      if (elem_ptr != 0)
         send_request(CMD_MASK, $urandom_range(0, 65535), $urandom_range(0, 255),
                      $urandom_range(0, 1), 1'b1);
   endtask

   task automatic send_vector(cmd_type cmd, int len, bit narrow);
      logic [LABEL_W-1:0] label;
      label = pick_label(narrow);
      for (int i = 0; i < len; i++)
         send_request(cmd, pick_feature(narrow), label, $urandom_range(0, 1),
                      i == len - 1);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_votes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_ADDR_W-1:0] addr,
                                 logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      req_tvalid <= 1'b0;
      csr_we     <= 1'b1;
      csr_addr   <= addr;
      csr_wdata  <= value;
      @(posedge clock);
      if (addr == CSR_ATTR_COUNT)
         attr_cnt = value[ATTR_CNT_W-1:0];
      else
         train_cnt = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_widest_vectors();
      wait_idle();
      write_register(CSR_ATTR_COUNT, MAX_ATTRS);
      write_register(CSR_TRAIN_COUNT, NEIGHBOURS);
      // only the leading attributes get mask bits; the rest stay clear from
      // reset, so the unwritten tail of every vector never counts
      send_vector(CMD_MASK, RANDOM_WIDTH, 1'b0);
      repeat (NEIGHBOURS) send_vector(CMD_TRAIN, RANDOM_WIDTH, 1'b0);
      send_vector(CMD_QUERY, RANDOM_WIDTH, 1'b0);
      wait_idle();
      write_register(CSR_ATTR_COUNT, 10'h3ff);
      send_vector(CMD_QUERY, RANDOM_WIDTH, 1'b1);
      wait_idle();
      // no attributes: every distance is zero
      write_register(CSR_ATTR_COUNT, 0);
      send_vector(CMD_QUERY, 1, 1'b0);
   endtask

   task automatic test_directed_cases();
      wait_idle();
      write_register(CSR_ATTR_COUNT, 2);
      write_register(CSR_TRAIN_COUNT, 6);
      send_request(CMD_MASK, 16'h1234, 8'h00, 1'b1, 1'b0);
      send_request(CMD_MASK, 16'hffff, 8'hff, 1'b1, 1'b1);
      send_request(CMD_TRAIN, 16'h8000, 8'h12, 1'b0, 1'b0);
      send_request(CMD_TRAIN, 16'h7fff, 8'hff, 1'b1, 1'b1);
      send_request(CMD_TRAIN, 16'h7fff, 8'h34, 1'b1, 1'b0);
      send_request(CMD_TRAIN, 16'h8000, 8'h00, 1'b0, 1'b1);
      send_request(CMD_TRAIN, 16'h0000, 8'h56, 1'b0, 1'b0);
      send_request(CMD_TRAIN, 16'h0000, 8'hff, 1'b0, 1'b1);
      // unused command, even with last set, leaves the pointer alone
      send_request(CMD_NONE, 16'hffff, 8'hff, 1'b1, 1'b1);
      send_request(CMD_QUERY, 16'h8000, 8'hff, 1'b1, 1'b0);
      send_request(CMD_QUERY, 16'h7fff, 8'hff, 1'b1, 1'b1);
      send_request(CMD_QUERY, 16'h7fff, 8'h00, 1'b0, 1'b0);
      send_request(CMD_QUERY, 16'h8000, 8'h00, 1'b0, 1'b1);
      // mask element 0 then query element 1: shared pointer carries on
      send_request(CMD_MASK, 16'h5555, 8'haa, 1'b0, 1'b0);
      send_request(CMD_QUERY, 16'h0000, 8'h55, 1'b1, 1'b1);
      for (int count = 0; count <= NEIGHBOURS; count++) begin
         wait_idle();
         write_register(CSR_TRAIN_COUNT, count);
         send_request(CMD_QUERY, 16'h0001, 8'h00, 1'b0, 1'b0);
         send_request(CMD_QUERY, 16'hfffe, 8'h00, 1'b0, 1'b1);
      end
   endtask

   task automatic test_long_search();
      bit narrow;
      wait_idle();
      write_register(CSR_ATTR_COUNT, 1);
      send_request(CMD_MASK, 16'h0000, 8'h00, 1'b1, 1'b1);
      repeat (LONG_EXAMPLES) begin
         narrow = ($urandom_range(0, 3) != 0);
         send_vector(CMD_TRAIN, 1, narrow);
      end
      // search every vector stored so far
      write_register(CSR_TRAIN_COUNT, CSR_DATA_W'(safe_examples(1)));
      repeat (3) send_vector(CMD_QUERY, 1, $urandom_range(0, 1));
      // all distances masked out: the last three vectors take the slots
      send_request(CMD_MASK, 16'h0000, 8'h00, 1'b0, 1'b1);
      send_vector(CMD_QUERY, 1, 1'b0);
   endtask

   task automatic test_random_sessions();
      int attrs, limit, len, count, qlen, start;
      bit narrow;
      start = requests_sent;
      while (requests_sent - start < RANDOM_REQUESTS) begin
         wait_idle();
         steady = ($urandom_range(0, 4) == 0);
         narrow = ($urandom_range(0, 2) != 0);
         attrs  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, RANDOM_WIDTH);
         write_register(CSR_ATTR_COUNT, attrs);
         if ($urandom_range(0, 2) == 0) begin
            align_pointer();
            send_vector(CMD_MASK, RANDOM_WIDTH, 1'b0);
         end
         repeat ($urandom_range(0, 5)) begin
            align_pointer();
            len = RANDOM_WIDTH;
            if ($urandom_range(0, 5) == 0)
               len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, RANDOM_WIDTH - 1)
                                                 : $urandom_range(RANDOM_WIDTH + 1, 12);
            send_vector(CMD_TRAIN, len, narrow);
         end
         limit = safe_examples(attrs);
         if (limit > 48) limit = 48;
         count = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                             : $urandom_range(NEIGHBOURS, limit);
         write_register(CSR_TRAIN_COUNT, count);
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 2) == 0)
               repeat ($urandom_range(1, 2)) send_noise();
            align_pointer();
            qlen = (attrs == 0) ? 1 : attrs;
            if ($urandom_range(0, 6) == 0) qlen += $urandom_range(1, 3);
            send_vector(CMD_QUERY, qlen, narrow);
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_widest_vectors();
      test_directed_cases();
      test_long_search();
      test_random_sessions();
      wait_idle();
      steady = 1'b1;
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d requests and %0d checked votes over every command,",
               requests_sent, votes_checked);
      $display("vectors of 0 to 512 attributes and searches of 0 to 48 stored vectors.");
      if (fails == 0 && pending_votes.size() == 0)
         $display("knn3_masked_classifier regression: pass");
      else
         $display("knn3_masked_classifier regression: fail");
      $finish;
   end

   initial begin
      #(TIMEOUT);
      $display("knn3_masked_classifier regression: fail");
      $finish;
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
         stall_left = idle_length() - 1;
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin
      vote_type         want;
      logic [7:0]       got_class;
      logic [9:0]       got_index;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_class = rsp_tdata[7:0];
         got_index = rsp_tdata[17:8];
         if (pending_votes.size() == 0) begin
            $error("unexpected result: predicted_class %0d, nearest_index %0d",
                   got_class, got_index);
            fails++;
         end else begin
            want = pending_votes.pop_front();
            votes_checked++;
            if (got_class !== want.predicted_class) begin
               $error("predicted_class: expected %0d, got %0d",
                      want.predicted_class, got_class);
               fails++;
            end
            if (got_index !== want.nearest_index) begin
               $error("nearest_index: expected %0d, got %0d",
                      want.nearest_index, got_index);
               fails++;
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ sim.f @@
sv/knn3_pkg.sv
sv/knn3_ram.sv
sv/knn3_mac.sv
sv/knn3_rank.sv
sv/knn3_masked_classifier.sv
tb/knn3_masked_classifier_tb.sv
